// ===== rtl/nearest_upsample_index_map_defines.svh =====
// Assertion macros for the nearest upsample index map.
// Used by the top level; no other dependencies.
`ifndef NEAREST_UPSAMPLE_INDEX_MAP_DEFINES_SVH
`define NEAREST_UPSAMPLE_INDEX_MAP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define NUI_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define NUI_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk_i) prop) else $error("assertion failed");
`else
`define NUI_ASSERT(label, prop)
`define NUI_ASSERT_RST(label, prop)
`endif
`endif

// ===== rtl/nui_pkg.sv =====
// Types, constants and helper functions for the nearest upsample index map.
// No dependencies.
package nui_pkg;

  localparam int INDEX_BITS = 24;
  localparam int DIM_BITS   = 12;

  localparam logic [23:0] IDX_MASK   = 24'((64'd1 << INDEX_BITS) - 64'd1);
  localparam logic [12:0] DIM_TOP    = 13'(1 << DIM_BITS);
  localparam logic [4:0]  SCALE_TOP  = 5'd16;
  localparam logic [30:0] RESULT_MAX = 31'h7FFF_FFFF;

  typedef enum logic [2:0] {
    CFG_DIRECTION = 3'd0,
    CFG_CHANNELS  = 3'd1,
    CFG_HEIGHT    = 3'd2,
    CFG_WIDTH     = 3'd3,
    CFG_SCALE     = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [23:0] flat_index;
    logic [3:0]  col_offset;
    logic [3:0]  row_offset;
  } in_item_t;

  typedef struct packed {
    logic [30:0] mapped_index;
    logic        overflow;
  } out_item_t;

  function automatic logic [12:0] clamp_dim(input logic [12:0] v);
    logic [12:0] r;
    r = v;
    if (v == 13'd0) r = 13'd1;
    else if (v > DIM_TOP) r = DIM_TOP;
    return r;
  endfunction

  function automatic logic [4:0] clamp_scale(input logic [4:0] v);
    logic [4:0] r;
    r = v;
    if (v == 5'd0) r = 5'd1;
    else if (v > SCALE_TOP) r = SCALE_TOP;
    return r;
  endfunction

  // Four restoring division steps: returns {remainder, quotient digit}
  function automatic logic [16:0] div4(input logic [12:0] rem, input logic [3:0] bits,
                                       input logic [12:0] dvs);
    logic [13:0] t;
    logic [12:0] r;
    logic [3:0]  q;
    r = rem;
    q = 4'd0;
    for (int i = 3; i >= 0; i--) begin
      t = {r, bits[i]};
      if (t >= {1'b0, dvs}) begin
        t    = t - {1'b0, dvs};
        q[i] = 1'b1;
      end
      r = t[12:0];
    end
    return {r, q};
  endfunction

endpackage

// ===== rtl/nearest_upsample_index_map.sv =====
// Top level of the nearest upsample index map: config registers and pipeline.
// Depends on nui_pkg and nearest_upsample_index_map_defines.svh.
//
//  channel | handshake            | payload
//  in      | in_valid_i/in_stall_o  | nui_pkg::in_item_t
//  out     | out_valid_o/out_stall_i| nui_pkg::out_item_t
//  cfg     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// One item per cycle unless the output stalls. 18 digit-per-stage division
// stages (width, height, channels, with the scale divisions in the first four
// channel stages), three multiply stages and the output register.
// Reset clears the valid bits and sets the registers to their reset values.
// A stall on a valid output holds the whole pipeline; nothing is dropped or repeated.
`include "nearest_upsample_index_map_defines.svh"
module nearest_upsample_index_map (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  nui_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output nui_pkg::out_item_t  out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [12:0]         cfg_data_i
);

  localparam int NSTG = 18;

  typedef struct packed {
    logic        v;
    logic [23:0] a;
    logic [12:0] r;
    logic [11:0] col;
    logic [11:0] row;
    logic [3:0]  coff;
    logic [3:0]  roff;
    logic [15:0] cs;
    logic [15:0] rs;
    logic [15:0] hs;
    logic [15:0] ws;
    logic [12:0] csr;
    logic [12:0] rsr;
    logic [12:0] hsr;
    logic [12:0] wsr;
  } stg_t;

  typedef struct packed {
    logic        v;
    logic [23:0] t1;
    logic [17:0] row;
    logic [17:0] col;
    logic [17:0] oh;
    logic [17:0] ow;
  } mul_t;

  logic        dir_q;
  logic [12:0] nc_q, nh_q, nw_q;
  logic [4:0]  sc_q;

  logic        adv;
  stg_t        st_q [NSTG];
  stg_t        st_d [NSTG];
  mul_t        m1_q, m1_d;
  logic        m2v_q;
  logic [29:0] m2t_q;
  logic [17:0] m2col_q, m2ow_q;
  logic        m3v_q;
  logic [40:0] m3t_q;
  logic        outv_q;
  nui_pkg::out_item_t out_q;

  assign adv         = !outv_q || !out_stall_i;
  assign in_stall_o  = !adv;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = outv_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= 1'b0;
      nc_q  <= 13'd1;
      nh_q  <= 13'd1;
      nw_q  <= 13'd1;
      sc_q  <= 5'd1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        nui_pkg::CFG_DIRECTION: dir_q <= cfg_data_i[0];
        nui_pkg::CFG_CHANNELS:  nc_q  <= nui_pkg::clamp_dim(cfg_data_i);
        nui_pkg::CFG_HEIGHT:    nh_q  <= nui_pkg::clamp_dim(cfg_data_i);
        nui_pkg::CFG_WIDTH:     nw_q  <= nui_pkg::clamp_dim(cfg_data_i);
        nui_pkg::CFG_SCALE:     sc_q  <= nui_pkg::clamp_scale(cfg_data_i[4:0]);
        default: ;
      endcase
    end
  end

  for (genvar k = 0; k < NSTG; k++) begin : g_div
    always_comb begin
      stg_t        s;
      logic [12:0] dvs;
      logic [16:0] rq;
      if (k == 0) begin
        s      = '0;
        s.v    = in_valid_i;
        s.a    = in_data_i.flat_index & nui_pkg::IDX_MASK;
        s.coff = in_data_i.col_offset;
        s.roff = in_data_i.row_offset;
      end else begin
        s = st_q[(k == 0) ? 0 : k - 1];
      end
      if (k == 6) begin
        s.col = s.r[11:0];
        s.r   = 13'd0;
      end
      if (k == 12) begin
        s.row = s.r[11:0];
        s.r   = 13'd0;
        s.cs  = {4'd0, s.col};
        s.rs  = {4'd0, s.row};
        s.hs  = {3'd0, nh_q};
        s.ws  = {3'd0, nw_q};
        s.csr = 13'd0;
        s.rsr = 13'd0;
        s.hsr = 13'd0;
        s.wsr = 13'd0;
      end
      dvs = (k < 6) ? nw_q : ((k < 12) ? nh_q : nc_q);
      rq  = nui_pkg::div4(s.r, s.a[23:20], dvs);
      s.r = rq[16:4];
      s.a = {s.a[19:0], rq[3:0]};
      if (k >= 12 && k < 16) begin
        rq    = nui_pkg::div4(s.csr, s.cs[15:12], {8'd0, sc_q});
        s.csr = rq[16:4];
        s.cs  = {s.cs[11:0], rq[3:0]};
        rq    = nui_pkg::div4(s.rsr, s.rs[15:12], {8'd0, sc_q});
        s.rsr = rq[16:4];
        s.rs  = {s.rs[11:0], rq[3:0]};
        rq    = nui_pkg::div4(s.hsr, s.hs[15:12], {8'd0, sc_q});
        s.hsr = rq[16:4];
        s.hs  = {s.hs[11:0], rq[3:0]};
        rq    = nui_pkg::div4(s.wsr, s.ws[15:12], {8'd0, sc_q});
        s.wsr = rq[16:4];
        s.ws  = {s.ws[11:0], rq[3:0]};
      end
      st_d[k] = s;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_q[k] <= '0;
      end else if (adv) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  always_comb begin
    stg_t        l;
    logic [36:0] p1;
    l      = st_q[NSTG-1];
    p1     = {13'd0, l.a} * {24'd0, nc_q} + {25'd0, l.r[11:0]};
    m1_d.v = l.v;
    m1_d.t1 = p1[23:0];
    if (dir_q) begin
      m1_d.col = 18'({6'd0, l.col} * {13'd0, sc_q} + {14'd0, l.coff});
      m1_d.row = 18'({6'd0, l.row} * {13'd0, sc_q} + {14'd0, l.roff});
      m1_d.oh  = 18'({5'd0, nh_q} * {13'd0, sc_q});
      m1_d.ow  = 18'({5'd0, nw_q} * {13'd0, sc_q});
    end else begin
      m1_d.col = {2'd0, l.cs};
      m1_d.row = {2'd0, l.rs};
      m1_d.oh  = {2'd0, l.hs};
      m1_d.ow  = {2'd0, l.ws};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_q    <= '0;
      m2v_q   <= 1'b0;
      m2t_q   <= '0;
      m2col_q <= '0;
      m2ow_q  <= '0;
      m3v_q   <= 1'b0;
      m3t_q   <= '0;
      outv_q  <= 1'b0;
      out_q   <= '0;
    end else if (adv) begin
      m1_q    <= m1_d;
      m2v_q   <= m1_q.v;
      m2t_q   <= 30'({18'd0, m1_q.t1} * {24'd0, m1_q.oh} + {24'd0, m1_q.row});
      m2col_q <= m1_q.col;
      m2ow_q  <= m1_q.ow;
      m3v_q   <= m2v_q;
      m3t_q   <= 41'({18'd0, m2t_q} * {30'd0, m2ow_q} + {30'd0, m2col_q});
      outv_q  <= m3v_q;
      if (m3t_q > {10'd0, nui_pkg::RESULT_MAX}) begin
        out_q.mapped_index <= nui_pkg::RESULT_MAX;
        out_q.overflow     <= 1'b1;
      end else begin
        out_q.mapped_index <= m3t_q[30:0];
        out_q.overflow     <= 1'b0;
      end
    end
  end

  `NUI_ASSERT(a_ovf_sat, out_valid_o && out_data_o.overflow |-> out_data_o.mapped_index == nui_pkg::RESULT_MAX)
  `NUI_ASSERT(a_shrink_no_ovf, out_valid_o && !dir_q |-> !out_data_o.overflow)
  `NUI_ASSERT(a_accept_enters, in_valid_i && !in_stall_o |=> st_q[0].v)
  `NUI_ASSERT_RST(a_reset_empty, !rst_ni |=> !out_valid_o)

endmodule

// ===== dv/nearest_upsample_index_map_test.sv =====
// Self-checking testbench for the nearest upsample index map.
// Predicts each mapped index from the configured shape and compares in order.
// Depends on nui_pkg and the nearest_upsample_index_map top level.
module nearest_upsample_index_map_test;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  nui_pkg::in_item_t  in_data_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  nui_pkg::out_item_t out_data_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [12:0]        cfg_data_i = '0;

  nearest_upsample_index_map u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic        reg_dir;
  logic [12:0] reg_chan, reg_height, reg_width;
  logic [4:0]  reg_scale;

  nui_pkg::out_item_t pending_idx[$];
  int          err_count = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  bit          hold_out = 1'b0;
  longint      cycle_cnt = 0;

  function automatic logic [12:0] eff_dim(logic [12:0] v);
    if (v == 13'd0) return 13'd1;
    if (v > 13'd4096) return 13'd4096;
    return v;
  endfunction

  function automatic nui_pkg::out_item_t map_index(nui_pkg::in_item_t it);
    longint unsigned idx, nc, nh, nw, s, col, row, ch, b, oh, ow, res;
    nui_pkg::out_item_t r;
    idx = it.flat_index;
    nc = eff_dim(reg_chan);
    nh = eff_dim(reg_height);
    nw = eff_dim(reg_width);
    s = (reg_scale == 0) ? 1 : ((reg_scale > 16) ? 16 : reg_scale);
    col = idx % nw; idx = idx / nw;
    row = idx % nh; idx = idx / nh;
    ch = idx % nc; b = idx / nc;
    if (reg_dir) begin
      col = col * s + it.col_offset;
      row = row * s + it.row_offset;
      oh = nh * s; ow = nw * s;
    end else begin
      col = col / s; row = row / s;
      oh = nh / s; ow = nw / s;
    end
    res = ((b * nc + ch) * oh + row) * ow + col;
    if (res > 64'h7FFF_FFFF) begin
      r.mapped_index = 31'h7FFF_FFFF;
      r.overflow = 1'b1;
    end else begin
      r.mapped_index = res[30:0];
      r.overflow = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 2000000) begin
      $display("nearest_upsample_index_map: mismatch");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    nui_pkg::out_item_t exp_item;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_idx.size() == 0) begin
        $error("unexpected item: mapped_index %0d", out_data_o.mapped_index);
        err_count++;
      end else begin
        exp_item = pending_idx.pop_front();
        if (out_data_o.mapped_index !== exp_item.mapped_index) begin
          $error("mapped_index: expected %0d, actual %0d",
                 exp_item.mapped_index, out_data_o.mapped_index);
          err_count++;
        end
        if (out_data_o.overflow !== exp_item.overflow) begin
          $error("overflow: expected %0d, actual %0d",
                 exp_item.overflow, out_data_o.overflow);
          err_count++;
        end
      end
    end
    out_stall_i <= hold_out || ($urandom_range(99) < stall_pct);
  end

  task automatic send_item(nui_pkg::in_item_t it);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    pending_idx.push_back(map_index(it));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_idx.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_reg(nui_pkg::cfg_idx_e idx, logic [12:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      nui_pkg::CFG_DIRECTION: reg_dir = val[0];
      nui_pkg::CFG_CHANNELS:  reg_chan = val;
      nui_pkg::CFG_HEIGHT:    reg_height = val;
      nui_pkg::CFG_WIDTH:     reg_width = val;
      nui_pkg::CFG_SCALE:     reg_scale = val[4:0];
      default: ;
    endcase
  endtask

  task automatic set_shape(logic d, logic [12:0] c, logic [12:0] h, logic [12:0] w,
                           logic [4:0] s);
    drain();
    write_reg(nui_pkg::CFG_DIRECTION, {12'd0, d});
    write_reg(nui_pkg::CFG_CHANNELS, c);
    write_reg(nui_pkg::CFG_HEIGHT, h);
    write_reg(nui_pkg::CFG_WIDTH, w);
    write_reg(nui_pkg::CFG_SCALE, {8'd0, s});
    cfg_valid_i <= 1'b0;
  endtask

  function automatic nui_pkg::in_item_t rand_item();
    nui_pkg::in_item_t it;
    it.flat_index = 24'($urandom());
    if ($urandom_range(3) == 0) it.flat_index = 24'($urandom_range(4095));
    it.col_offset = 4'($urandom());
    it.row_offset = 4'($urandom());
    return it;
  endfunction

  function automatic logic [12:0] rand_dim();
    case ($urandom_range(5))
      0: return 13'd0;
      1: return 13'd4096;
      2: return 13'($urandom_range(8191, 4097));
      3: return 13'($urandom_range(16, 1));
      default: return 13'($urandom_range(4096, 1));
    endcase
  endfunction

  task automatic test_directed();
    nui_pkg::in_item_t it;
    logic [23:0] vals[6] = '{24'd0, 24'hFFFFFF, 24'h800000, 24'h0AAAAA, 24'h555555, 24'd37};
    set_shape(1'b0, 13'd3, 13'd5, 13'd7, 5'd2);
    foreach (vals[i]) begin
      it.flat_index = vals[i]; it.col_offset = 4'hF; it.row_offset = 4'h0;
      send_item(it);
    end
    set_shape(1'b1, 13'd4096, 13'd4096, 13'd4096, 5'd16);
    foreach (vals[i]) begin
      it.flat_index = vals[i]; it.col_offset = 4'hF; it.row_offset = 4'hF;
      send_item(it);
    end
    set_shape(1'b0, 13'd0, 13'd3, 13'd2, 5'd31);
    for (int i = 0; i < 4; i++) send_item(rand_item());
    set_shape(1'b1, 13'd8191, 13'd0, 13'd8191, 5'd0);
    for (int i = 0; i < 4; i++) send_item(rand_item());
    set_shape(1'b1, 13'd1, 13'd1, 13'd1, 5'd1);
    for (int i = 0; i < 4; i++) send_item(rand_item());
  endtask

  task automatic test_random();
    int pcts[4][2] = '{'{0, 0}, '{61, 0}, '{0, 61}, '{27, 27}};
    for (int ph = 0; ph < 32; ph++) begin
      set_shape(1'($urandom()), rand_dim(), rand_dim(), rand_dim(), 5'($urandom()));
      send_idle_pct = pcts[ph % 4][0];
      stall_pct = pcts[ph % 4][1];
      for (int i = 0; i < 50; i++) send_item(rand_item());
    end
    send_idle_pct = 0;
    stall_pct = 0;
  endtask

  task automatic test_backpressure();
    set_shape(1'b1, 13'd5, 13'd9, 13'd11, 5'd3);
    fork
      begin
        hold_out = 1'b1;
        repeat (200) @(posedge clk_i);
        hold_out = 1'b0;
      end
      for (int i = 0; i < 60; i++) send_item(rand_item());
    join
    drain();
    for (int i = 0; i < 20; i++) send_item(rand_item());
  endtask

  initial begin
    reg_dir = 1'b0; reg_chan = 13'd1; reg_height = 13'd1;
    reg_width = 13'd1; reg_scale = 5'd1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random();
    test_backpressure();
    drain();
    if (err_count == 0) begin
      $display("nearest_upsample_index_map: match");
    end else begin
      $display("nearest_upsample_index_map: mismatch");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/nui_pkg.sv
rtl/nearest_upsample_index_map.sv
dv/nearest_upsample_index_map_test.sv
